FILE: rtl/assert_macros.svh
// Assertion helpers for the mark/space pulse player RTL.
// Clocked, reset-qualified property checks that report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLKD(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/irp_pkg.sv
// Shared types and constants for the mark/space pulse player.
// No dependencies; imported by irp_cfg, irp_ctrl and the top level.
`timescale 1ns / 1ps

package irp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 256;

  localparam int unsigned TickW    = 10;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned DurW     = 28;
  localparam int unsigned EntryW   = DurW + 1;
  localparam int unsigned TimeW    = 30;
  localparam int unsigned DiffW    = TimeW + 2;
  localparam int unsigned OutCntW  = 8;
  localparam int unsigned LostW    = 16;
  localparam int unsigned MsW      = 32;
  localparam int unsigned AccW     = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [AccW-1:0] US_PER_TICK_CLOCK = AccW'(50);
  localparam logic [AccW-1:0] US_PER_MS         = AccW'(1000);

  localparam logic [TimeW-1:0] TIME_MIN = {1'b1, {(TimeW-1){1'b0}}};

  localparam logic [TickW-1:0]   TICK_PERIOD_RST    = TickW'(50);
  localparam logic [PeriodW-1:0] CARRIER_PERIOD_RST = PeriodW'(684);
  localparam logic [PeriodW-1:0] CARRIER_DUTY_RST   = PeriodW'(342);

  typedef enum logic [1:0] {
    REQ_PUSH_MARK  = 2'd0,
    REQ_PUSH_SPACE = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_PERIOD    = 3'd0,
    CFG_CARRIER_PERIOD = 3'd1,
    CFG_CARRIER_DUTY   = 3'd2,
    CFG_IDLE_POL_HIGH  = 3'd3,
    CFG_ALLOW_RX_TX    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0]   tick_period;
    logic [PeriodW-1:0] carrier_period;
    logic [PeriodW-1:0] carrier_duty;
    logic               idle_polarity_high;
    logic               allow_rx_during_tx;
  } cfg_t;

endpackage

FILE: rtl/irp_ring.sv
// Pulse ring storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module irp_ring #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 29
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/irp_cfg.sv
// Configuration register file for the pulse player.
// Depends on irp_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module irp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [irp_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output irp_pkg::cfg_t                   cfg_o
);
  import irp_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period        <= TICK_PERIOD_RST;
      cfg_q.carrier_period     <= CARRIER_PERIOD_RST;
      cfg_q.carrier_duty       <= CARRIER_DUTY_RST;
      cfg_q.idle_polarity_high <= 1'b0;
      cfg_q.allow_rx_during_tx <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TICK_PERIOD:    cfg_q.tick_period        <= cfg_wdata_i[TickW-1:0];
        CFG_CARRIER_PERIOD: cfg_q.carrier_period     <= cfg_wdata_i[PeriodW-1:0];
        CFG_CARRIER_DUTY:   cfg_q.carrier_duty       <= cfg_wdata_i[PeriodW-1:0];
        CFG_IDLE_POL_HIGH:  cfg_q.idle_polarity_high <= cfg_wdata_i[0];
        CFG_ALLOW_RX_TX:    cfg_q.allow_rx_during_tx <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/irp_ctrl.sv
// Request sequencer and pulse datapath: queue pointers, pulse countdown, clock.
// Depends on irp_pkg; drives the ports of irp_ring.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irp_ctrl #(
  parameter int unsigned Depth = irp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    req_type_i,
  input  logic [irp_pkg::DurW-1:0]      duration_us_i,
  input  irp_pkg::cfg_t                 cfg_i,
  output logic                          ring_we_o,
  output logic [$clog2(Depth)-1:0]      ring_waddr_o,
  output logic [irp_pkg::EntryW-1:0]    ring_wdata_o,
  output logic [$clog2(Depth)-1:0]      ring_raddr_o,
  input  logic [irp_pkg::EntryW-1:0]    ring_rdata_i,
  output logic                          done_o,
  output logic                          push_accepted_o,
  output logic [irp_pkg::PeriodW-1:0]   duty_value_o,
  output logic                          line_level_o,
  output logic                          sending_o,
  output logic                          rx_enable_o,
  output logic [irp_pkg::OutCntW-1:0]   queued_entries_o,
  output logic [irp_pkg::LostW-1:0]     overflow_count_o,
  output logic [irp_pkg::MsW-1:0]       elapsed_ms_o
);
  import irp_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = (IdxW > OutCntW) ? IdxW : OutCntW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   done_q, push_acc_q, sending_q, rx_en_q;
  logic [PeriodW-1:0] duty_q;

  req_e                    req_q;
  logic [DurW-1:0]         dur_q;
  logic signed [DiffW-1:0] diff_q;

  logic [IdxW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LostW-1:0] lost_q, lost_d;
  logic [TimeW-1:0] tl_q, tl_d;
  logic             mark_q, mark_d;
  logic [AccW-1:0]  acc_q, acc_d, acc_sum;
  logic [MsW-1:0]   ms_q, ms_d;

  logic accept, exec;
  logic empty, full, tl_nz, diff_le0, do_pop, sat;
  logic [IdxW-1:0]  wr_next, rd_next;
  logic [EntryW-1:0] entry;
  logic entry_zero, entry_mark;
  logic [DurW-1:0] entry_dur;
  logic signed [DiffW-1:0] diff_d, carried;
  logic push_acc_d, sending_d;
  logic [PeriodW-1:0] duty_d;

  assign accept = start_i && (state_q == ST_IDLE);
  assign exec   = (state_q == ST_EXEC);
  assign busy_o = exec;

  assign diff_d = DiffW'($signed(tl_q)) - $signed({{(DiffW-TickW){1'b0}}, cfg_i.tick_period});

  assign empty      = (wr_q == rd_q);
  assign wr_next    = (wr_q == LastIdx) ? '0 : wr_q + IdxW'(1);
  assign rd_next    = (rd_q == LastIdx) ? '0 : rd_q + IdxW'(1);
  assign full       = (wr_next == rd_q);
  assign entry      = empty ? '0 : ring_rdata_i;
  assign entry_zero = (entry == '0);
  assign entry_mark = entry[EntryW-1];
  assign entry_dur  = entry[DurW-1:0];
  assign tl_nz      = (tl_q != '0);
  assign diff_le0   = diff_q[DiffW-1] || (diff_q == '0);
  assign do_pop     = !tl_nz || diff_le0;
  assign carried    = diff_q + $signed({{(DiffW-DurW){1'b0}}, entry_dur});
  assign sat        = !((carried[DiffW-1:TimeW-1] == '0) || (carried[DiffW-1:TimeW-1] == '1));
  assign acc_sum    = acc_q + US_PER_TICK_CLOCK;

  assign ring_waddr_o = wr_q;
  assign ring_wdata_o = {(req_q == REQ_PUSH_MARK), dur_q};
  assign ring_raddr_o = rd_q;

  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    cnt_d      = cnt_q;
    lost_d     = lost_q;
    tl_d       = tl_q;
    mark_d     = mark_q;
    acc_d      = acc_q;
    ms_d       = ms_q;
    push_acc_d = 1'b0;
    sending_d  = 1'b0;
    ring_we_o  = 1'b0;
    case (req_q)
      REQ_PUSH_MARK, REQ_PUSH_SPACE: begin
        if (!full) begin
          ring_we_o  = exec;
          wr_d       = wr_next;
          cnt_d      = cnt_q + CntW'(1);
          push_acc_d = 1'b1;
        end else begin
          lost_d = lost_q + LostW'(1);
        end
      end
      REQ_TICK: begin
        if (acc_sum >= US_PER_MS) begin
          acc_d = acc_sum - US_PER_MS;
          ms_d  = ms_q + MsW'(1);
        end else begin
          acc_d = acc_sum;
        end
        if (do_pop && !empty) begin
          rd_d  = rd_next;
          cnt_d = cnt_q - CntW'(1);
        end
        if (tl_nz) begin
          sending_d = 1'b1;
          if (diff_le0) begin
            if (entry_zero) begin
              tl_d   = '0;
              mark_d = 1'b0;
            end else begin
              mark_d = entry_mark;
              tl_d   = sat ? TIME_MIN : carried[TimeW-1:0];
            end
          end else begin
            tl_d = diff_q[TimeW-1:0];
          end
        end else if (entry_zero) begin
          tl_d   = '0;
          mark_d = 1'b0;
        end else begin
          sending_d = 1'b1;
          tl_d      = {{(TimeW-DurW){1'b0}}, entry_dur};
          mark_d    = entry_mark;
        end
      end
      REQ_CLEAR: begin
        wr_d   = '0;
        rd_d   = '0;
        cnt_d  = '0;
        lost_d = '0;
        tl_d   = '0;
        mark_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (mark_d) begin
      duty_d = cfg_i.carrier_duty;
    end else if (cfg_i.idle_polarity_high) begin
      duty_d = cfg_i.carrier_period;
    end else begin
      duty_d = '0;
    end
  end

  // Hold the request and the precomputed countdown for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      dur_q  <= duration_us_i;
      diff_q <= diff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      push_acc_q <= 1'b0;
      sending_q  <= 1'b0;
      rx_en_q    <= 1'b0;
      duty_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q    <= ST_IDLE;
          done_q     <= 1'b1;
          push_acc_q <= push_acc_d;
          sending_q  <= sending_d;
          rx_en_q    <= cfg_i.allow_rx_during_tx || !sending_d;
          duty_q     <= duty_d;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      lost_q <= '0;
      tl_q   <= '0;
      mark_q <= 1'b0;
      acc_q  <= '0;
      ms_q   <= '0;
    end else if (exec) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      lost_q <= lost_d;
      tl_q   <= tl_d;
      mark_q <= mark_d;
      acc_q  <= acc_d;
      ms_q   <= ms_d;
    end
  end

  assign done_o           = done_q;
  assign push_accepted_o  = push_acc_q;
  assign duty_value_o     = duty_q;
  assign line_level_o     = mark_q;
  assign sending_o        = sending_q;
  assign rx_enable_o      = rx_en_q;
  assign queued_entries_o = cnt_q[OutCntW-1:0];
  assign overflow_count_o = lost_q;
  assign elapsed_ms_o     = ms_q;

  `ASSERT_CLKD(a_count_matches_ptrs, clk_i, rst_ni, (cnt_q == '0) == (wr_q == rd_q))
  `ASSERT_NEXT(a_exec_gives_done, clk_i, rst_ni, exec, done_q && (state_q == ST_IDLE))
  `ASSERT_IMPL(a_done_follows_exec, clk_i, rst_ni, done_q, $past(state_q) == ST_EXEC)
  `ASSERT_IMPL(a_write_only_with_room, clk_i, rst_ni, ring_we_o, exec && !full)

endmodule

FILE: rtl/ir_mark_space_pulse_player.sv
// Top level of the mark/space pulse player.
// Depends on irp_pkg, irp_cfg, irp_ring and irp_ctrl.
`timescale 1ns / 1ps

// Each request (push mark, push space, tick, queue reset) is taken when start is
// high and busy is low: the accept cycle reads the ring at the read pointer, the
// next cycle uses the registered read data to update the queue, the pulse
// countdown and the clock, and writes a pushed entry. The result shows on the
// result ports with done_o high for exactly one cycle right after that, and the
// receiver cannot stall it; a new request may be started in that same cycle, but
// not while busy is high. The ring needs no clearing pass after reset: only
// entries that were pushed are ever popped.
module ir_mark_space_pulse_player #(
  parameter int unsigned QueueDepth = irp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [irp_pkg::DurW-1:0]      duration_us_i,
  input  logic                          cfg_we_i,
  input  logic [irp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [irp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                          done_o,
  output logic                          push_accepted_o,
  output logic [irp_pkg::PeriodW-1:0]   duty_value_o,
  output logic                          line_level_o,
  output logic                          sending_o,
  output logic                          rx_enable_o,
  output logic [irp_pkg::OutCntW-1:0]   queued_entries_o,
  output logic [irp_pkg::LostW-1:0]     overflow_count_o,
  output logic [irp_pkg::MsW-1:0]       elapsed_ms_o
);
  import irp_pkg::*;

  localparam int unsigned IdxW = $clog2(QueueDepth);

  cfg_t              cfg;
  logic              ring_we;
  logic [IdxW-1:0]   ring_waddr, ring_raddr;
  logic [EntryW-1:0] ring_wdata, ring_rdata;

  irp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irp_ring #(
    .Depth (QueueDepth),
    .Width (EntryW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  irp_ctrl #(
    .Depth (QueueDepth)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .req_type_i       (req_type_i),
    .duration_us_i    (duration_us_i),
    .cfg_i            (cfg),
    .ring_we_o        (ring_we),
    .ring_waddr_o     (ring_waddr),
    .ring_wdata_o     (ring_wdata),
    .ring_raddr_o     (ring_raddr),
    .ring_rdata_i     (ring_rdata),
    .done_o           (done_o),
    .push_accepted_o  (push_accepted_o),
    .duty_value_o     (duty_value_o),
    .line_level_o     (line_level_o),
    .sending_o        (sending_o),
    .rx_enable_o      (rx_enable_o),
    .queued_entries_o (queued_entries_o),
    .overflow_count_o (overflow_count_o),
    .elapsed_ms_o     (elapsed_ms_o)
  );

endmodule
